// ===== design/mip_pkg.sv =====
// shared constants and types for the modular inverse unit
// prime modulus, fixed exponent, barrett constant and the side-band tag
// no dependencies
package mip_pkg;

    localparam int unsigned DATA_W   = 30;
    localparam int unsigned EXP_BITS = 30;

    localparam logic [DATA_W-1:0] MODULUS  = 30'd998244353;
    localparam logic [DATA_W-1:0] EXPONENT = MODULUS - 30'd2;
    localparam logic [DATA_W-1:0] ONE      = 30'd1;

    // floor(2^60 / modulus) for barrett reduction
    localparam logic [63:0] MU_FULL    = (64'd1 << 60) / {34'd0, MODULUS};
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] base;
    } mip_tag_t;

endpackage

// ===== design/mip_modmul.sv =====
// four-stage modular multiplier: product, barrett quotient, quotient times
// modulus, subtract and correct; carries a tag alongside the data
// depends on mip_pkg
module mip_modmul import mip_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  mip_tag_t          in_tag,
    input  logic [DATA_W-1:0] in_a,
    input  logic [DATA_W-1:0] in_b,
    output mip_tag_t          out_tag,
    output logic [DATA_W-1:0] out_res
);

    logic [3:0]        valid_reg;
    logic [DATA_W-1:0] base1_reg, base2_reg, base3_reg, base4_reg;

    logic [59:0] prod_next, prod_reg;
    logic [61:0] q2_next, q2_reg;
    logic [31:0] xlo2_reg, xlo3_reg;
    logic [60:0] qp_full;
    logic [31:0] qp_reg;
    logic [31:0] mod32;
    logic [31:0] r_raw, r_one, r_two;
    logic [DATA_W-1:0] res_next, res_reg;

    assign prod_next = in_a * in_b;
    assign q2_next   = prod_reg[59:29] * BARRETT_MU;
    assign qp_full   = q2_reg[61:31] * MODULUS;
    assign mod32     = {2'b00, MODULUS};

    always_comb begin
        r_raw    = xlo3_reg - qp_reg;
        r_one    = (r_raw >= mod32) ? r_raw - mod32 : r_raw;
        r_two    = (r_one >= mod32) ? r_one - mod32 : r_one;
        res_next = r_two[DATA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_tag.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            base1_reg <= in_tag.base;
            q2_reg    <= q2_next;
            xlo2_reg  <= prod_reg[31:0];
            base2_reg <= base1_reg;
            qp_reg    <= qp_full[31:0];
            xlo3_reg  <= xlo2_reg;
            base3_reg <= base2_reg;
            res_reg   <= res_next;
            base4_reg <= base3_reg;
        end
    end

    assign out_tag.valid = valid_reg[3];
    assign out_tag.base  = base4_reg;
    assign out_res       = res_reg;

    a_res_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[3] |-> (res_reg < MODULUS))
        else $error("modmul result not reduced");

    a_barrett_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[2] |-> (r_raw < 32'd2994733059))
        else $error("barrett remainder out of range");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(valid_reg) && $stable(res_reg)))
        else $error("modmul pipeline moved while stalled");

endmodule

// ===== design/mip_cell.sv =====
// one exponent-bit cell: square the accumulator, then multiply by the base
// when this cell's exponent bit is set (otherwise by one)
// depends on mip_pkg and mip_modmul
module mip_cell import mip_pkg::*; #(
    parameter logic EXP_BIT = 1'b1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  mip_tag_t          in_tag,
    input  logic [DATA_W-1:0] in_acc,
    output mip_tag_t          out_tag,
    output logic [DATA_W-1:0] out_acc
);

    mip_tag_t          sq_tag;
    logic [DATA_W-1:0] sq_res;
    logic [DATA_W-1:0] mul_b;

    mip_modmul u_square (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_tag  (in_tag),
        .in_a    (in_acc),
        .in_b    (in_acc),
        .out_tag (sq_tag),
        .out_res (sq_res)
    );

    assign mul_b = EXP_BIT ? sq_tag.base : ONE;

    mip_modmul u_multiply (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_tag  (sq_tag),
        .in_a    (sq_res),
        .in_b    (mul_b),
        .out_tag (out_tag),
        .out_res (out_acc)
    );

endmodule

// ===== design/modular_inverse_prime_unit.sv =====
// top level of the modular inverse unit for the prime 998244353
// depends on mip_pkg, mip_cell and mip_modmul
//
// Returns value^(p-2) mod p for p = 998244353, the multiplicative inverse of
// every nonzero residue; zero gives zero and inputs at or above p are reduced
// first. One transaction is accepted per cycle while the chain advances, and
// results leave in order. The datapath is one input register, then a chain
// of 30 cells, one per exponent bit, each holding a square and a multiply of
// four pipeline stages apiece. The whole chain advances together whenever
// the output register is empty or being taken, so s_tready follows m_tready.
module modular_inverse_prime_unit import mip_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [29:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [29:0] inverse
);

    logic              en;
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_base_reg;
    logic [DATA_W-1:0] value_in;
    logic [DATA_W-1:0] value_red;

    mip_tag_t          tag_chain [0:EXP_BITS];
    logic [DATA_W-1:0] acc_chain [0:EXP_BITS];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign value_in  = s_tdata[DATA_W-1:0];
    assign value_red = (value_in >= MODULUS) ? value_in - MODULUS : value_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_base_reg <= value_red;
        end
    end

    assign tag_chain[0].valid = in_valid_reg;
    assign tag_chain[0].base  = in_base_reg;
    assign acc_chain[0]       = ONE;

    for (genvar i = 0; i < EXP_BITS; i++) begin : g_cell
        mip_cell #(
            .EXP_BIT (EXPONENT[EXP_BITS-1-i])
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_tag  (tag_chain[i]),
            .in_acc  (acc_chain[i]),
            .out_tag (tag_chain[i+1]),
            .out_acc (acc_chain[i+1])
        );
    end

    assign m_tvalid = tag_chain[EXP_BITS].valid;
    assign m_tdata  = {2'b00, acc_chain[EXP_BITS]};

endmodule

// ===== verif/mip_checker.sv =====
// result checker for the modular inverse unit: watches both stream channels
// predicts each inverse by square-and-multiply and compares in order
// depends on mip_pkg
module mip_checker import mip_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int unsigned mismatch_count,
    output int unsigned pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DATA_W-1:0] inverse_q[$];

    function automatic logic [DATA_W-1:0] pow_p_minus_two(input logic [DATA_W-1:0] raw);
        logic [63:0] prime;
        logic [63:0] base;
        logic [63:0] acc;
        prime = {34'd0, MODULUS};
        base  = {34'd0, raw} % prime;
        acc   = 64'd1;
        for (int b = EXP_BITS - 1; b >= 0; b--) begin
            acc = (acc * acc) % prime;
            if (EXPONENT[b]) begin
                acc = (acc * base) % prime;
            end
        end
        return acc[DATA_W-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [DATA_W-1:0] want;
        if (!aresetn) begin
            mismatch_count = 0;
            pending_count  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                inverse_q.push_back(pow_p_minus_two(s_tdata[DATA_W-1:0]));
            end
            if (m_tvalid && m_tready) begin
                if (inverse_q.size() == 0) begin
                    $error("inverse: no transaction pending, got %0d", m_tdata[DATA_W-1:0]);
                    mismatch_count++;
                end else begin
                    want = inverse_q.pop_front();
                    if (m_tdata[DATA_W-1:0] !== want) begin
                        $error("inverse: expected %0d, got %0d", want, m_tdata[DATA_W-1:0]);
                        mismatch_count++;
                    end
                end
            end
            pending_count = inverse_q.size();
        end
    end

endmodule

// ===== verif/tb_modular_inverse_prime_unit.sv =====
// testbench top for the modular inverse unit: clock, reset, bursty residue
// stimulus, a stalling result sink and the final verdict
// depends on mip_pkg, mip_checker and modular_inverse_prime_unit
module tb_modular_inverse_prime_unit;
    import mip_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned cycle_count;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    modular_inverse_prime_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mip_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // sink stall modes, each held for a random stretch
    int unsigned sink_mode;
    int unsigned sink_left;
    int unsigned sink_tick;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_mode <= 0;
            sink_left <= 0;
            sink_tick <= 0;
        end else begin
            sink_tick <= sink_tick + 1;
            if (sink_left == 0) begin
                sink_mode <= $urandom_range(0, 3);
                sink_left <= $urandom_range(10, 400);
            end else begin
                sink_left <= sink_left - 1;
            end
            case (sink_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= (sink_tick[2:0] != 3'd0);
                end
            endcase
        end
    end

    task automatic send_residue(input logic [DATA_W-1:0] v);
        s_tdata  <= {2'b00, v};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [DATA_W-1:0] pick_residue();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            return DATA_W'($urandom_range(0, MODULUS - 1));
        end else if (kind == 6) begin
            return DATA_W'($urandom_range(MODULUS, 30'h3FFF_FFFF));
        end else if (kind == 7) begin
            return DATA_W'($urandom_range(0, 255));
        end else if (kind == 8) begin
            return MODULUS - 30'd1 - DATA_W'($urandom_range(0, 255));
        end
        return DATA_W'($urandom() & 32'h3FFF_FFFF);
    endfunction

    // zero, unit, extremes, the modulus itself and values above it
    logic [DATA_W-1:0] corner_values[16] = '{
        30'd0, 30'd1, 30'd2, 30'd3,
        MODULUS - 30'd1, MODULUS - 30'd2,
        (MODULUS - 30'd1) >> 1, (MODULUS + 30'd1) >> 1,
        MODULUS, MODULUS + 30'd1, MODULUS + 30'd2,
        30'h3FFF_FFFF, 30'h3FFF_FFFE,
        30'h2AAA_AAAA, 30'h1555_5555, 30'h2000_0000
    };

    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        sent = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (corner_values[i]) begin
            send_residue(corner_values[i]);
        end
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
                send_residue(pick_residue());
                sent++;
            end
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mip_pkg.sv
design/mip_modmul.sv
design/mip_cell.sv
design/modular_inverse_prime_unit.sv
verif/mip_checker.sv
verif/tb_modular_inverse_prime_unit.sv
